// ===== sv/mpt_pkg.sv =====
`default_nettype none

package mpt_pkg;

    // Default geometry and element format
    localparam int MAX_DIM_DEF    = 64;
    localparam int ELEM_WIDTH_DEF = 32;

    // Fixed field widths of the channels and the configuration port
    localparam int KIND_W     = 2;
    localparam int IDX_W      = 6;
    localparam int VAL_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int MODE_W     = 2;
    localparam int DIM_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_WRITE_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE_B = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

    // Product modes
    localparam logic [MODE_W-1:0] MODE_AB  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ATB = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ABT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRODUCT_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_A_COLS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS       = 3'd4;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_SAT   = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_ROUND,
        ST_FIN
    } mpt_state_t;

endpackage

`default_nettype wire

// ===== sv/mpt_if.sv =====
`default_nettype none

// Request channel: element writes and compute requests
interface mpt_req_if
    import mpt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  col_index;
    logic [VAL_W-1:0]  element_value;

    modport source (output valid, kind, row_index, col_index, element_value, input ready);
    modport sink   (input valid, kind, row_index, col_index, element_value, output ready);
endinterface

// Result channel: one beat per compute request
interface mpt_res_if
    import mpt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    out_row;
    logic [IDX_W-1:0]    out_col;
    logic [VAL_W-1:0]    product_value;
    logic [STATUS_W-1:0] status;

    modport source (output valid, out_row, out_col, product_value, status, input ready);
    modport sink   (input valid, out_row, out_col, product_value, status, output ready);
endinterface

`default_nettype wire

// ===== sv/mpt_ram.sv =====
`default_nettype none

module mpt_ram
    import mpt_pkg::*;
#(
    parameter int WIDTH = ELEM_WIDTH_DEF,
    parameter int DEPTH = MAX_DIM_DEF * MAX_DIM_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/matrix_product_transpose_modes.sv =====
`default_nettype none

// Channel   Direction  Beat carries
// --------  ---------  -------------------------------------------------------
// req       in         kind, row_index, col_index, element_value
// res       out        out_row, out_col, product_value, status
// cfg_*     in         plain write: cfg_we, cfg_index, cfg_data (no handshake)
//
// Writes give no beat. A compute holds the input low until its beat is loaded:
// one multiply-accumulate per A/B pair behind a registered RAM read, then a rounding
// state, then the output register. An out-of-range request goes straight to the finish
// state and returns its beat there. Reset sets the configuration, the sequencer and
// the beat valid; the datapath registers and the element stores are not cleared.
// A stalled beat lets requests through until the next compute finishes; that one holds.

module matrix_product_transpose_modes
    import mpt_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    mpt_req_if.sink                    req,
    mpt_res_if.source                  res
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int DCW    = (CNT_W > DIM_W) ? CNT_W : DIM_W;
    localparam int EW     = ELEM_WIDTH;
    localparam int FRAC   = EW - 8;
    localparam int PROD_W = 2 * EW;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

    // Configuration registers
    logic [MODE_W-1:0] mode_reg;
    logic [DIM_W-1:0]  a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;

    // Sequencer and datapath
    mpt_state_t state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, inner_reg;
    logic [AW-1:0]     a_ptr_reg, b_ptr_reg;
    logic              a_far_reg, b_far_reg;
    logic              dv_reg, pv_reg, oob_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, sum_reg;
    logic [IDX_W-1:0]  row_reg, col_reg;

    // Output register
    logic                res_valid_reg;
    logic [IDX_W-1:0]    res_row_reg, res_col_reg;
    logic [VAL_W-1:0]    res_value_reg;
    logic [STATUS_W-1:0] res_status_reg;

    // Control decoded from state
    logic accept, issue, run_done, load;

    // Geometry at acceptance
    logic [MODE_W-1:0] mode_eff;
    logic [CNT_W-1:0]  ar, ac, br, bc, nrow, ncol, inner;
    logic              oob;
    logic [AW-1:0]     a_start, b_start, waddr;
    logic              wr_range, we_a, we_b;

    // RAM read data
    logic [EW-1:0] a_rdata, b_rdata;

    // Result formatting
    logic signed [ACC_W-1:0] shifted;
    logic                    fits;
    logic [EW-1:0]           fin_value;
    status_t                 fin_status;

    function automatic logic [CNT_W-1:0] dim_clamp(input logic [DIM_W-1:0] d);
        logic [CNT_W-1:0] r;
        if (DCW'(d) > DCW'(MAX_DIM))
            r = CNT_W'(MAX_DIM);
        else
            r = CNT_W'(d);
        return r;
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_AB;
            a_rows_reg <= DIM_W'(1);
            a_cols_reg <= DIM_W'(1);
            b_rows_reg <= DIM_W'(1);
            b_cols_reg <= DIM_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PRODUCT_MODE: mode_reg   <= cfg_data[MODE_W-1:0];
                CFG_A_ROWS:       a_rows_reg <= cfg_data[DIM_W-1:0];
                CFG_A_COLS:       a_cols_reg <= cfg_data[DIM_W-1:0];
                CFG_B_ROWS:       b_rows_reg <= cfg_data[DIM_W-1:0];
                CFG_B_COLS:       b_cols_reg <= cfg_data[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    // Decode the mode; the unused code behaves as A times B
    always_comb
    begin
        unique case (mode_reg)
            MODE_ATB: mode_eff = MODE_ATB;
            MODE_ABT: mode_eff = MODE_ABT;
            default:  mode_eff = MODE_AB;
        endcase
    end

    // Result size, inner length and start addresses for the request on the port
    always_comb
    begin
        ar = dim_clamp(a_rows_reg);
        ac = dim_clamp(a_cols_reg);
        br = dim_clamp(b_rows_reg);
        bc = dim_clamp(b_cols_reg);
        unique case (mode_eff)
            MODE_ATB:
            begin
                nrow  = ac;
                ncol  = bc;
                inner = (ar < br) ? ar : br;
            end
            MODE_ABT:
            begin
                nrow  = ar;
                ncol  = br;
                inner = (ac < bc) ? ac : bc;
            end
            default:
            begin
                nrow  = ar;
                ncol  = bc;
                inner = (ac < br) ? ac : br;
            end
        endcase
        oob = (DCW'(req.row_index) >= DCW'(nrow)) || (DCW'(req.col_index) >= DCW'(ncol));
        a_start = (mode_eff == MODE_ATB) ? AW'(req.row_index)
                                         : AW'(req.row_index * MAX_DIM);
        b_start = (mode_eff == MODE_ABT) ? AW'(req.col_index * MAX_DIM)
                                         : AW'(req.col_index);
    end

    // Element writes land straight in the stores; outside the store they drop
    assign wr_range = (DCW'(req.row_index) < DCW'(MAX_DIM))
                   && (DCW'(req.col_index) < DCW'(MAX_DIM));
    assign waddr = AW'(req.row_index * MAX_DIM + req.col_index);
    assign we_a  = accept && (req.kind == KIND_WRITE_A) && wr_range;
    assign we_b  = accept && (req.kind == KIND_WRITE_B) && wr_range;

    mpt_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (req.element_value[EW-1:0]),
        .raddr (a_ptr_reg),
        .rdata (a_rdata)
    );

    mpt_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (req.element_value[EW-1:0]),
        .raddr (b_ptr_reg),
        .rdata (b_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && (req.kind == KIND_COMPUTE))
                    state_next = oob ? ST_FIN : ST_RUN;
            end
            ST_RUN:
            begin
                if (run_done)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        req.ready = 1'b0;
        issue     = 1'b0;
        run_done  = 1'b0;
        load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_RUN:
            begin
                issue    = (cnt_reg != inner_reg);
                run_done = (cnt_reg == inner_reg) && !dv_reg && !pv_reg;
            end
            ST_ROUND:
            begin
            end
            ST_FIN:
            begin
                load = !res_valid_reg || res.ready;
            end
            default:
            begin
            end
        endcase
    end

    assign accept = req.valid && req.ready;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            dv_reg    <= 1'b0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dv_reg    <= issue;
            pv_reg    <= dv_reg;
            if (accept)
                cnt_reg <= '0;
            else if (issue)
                cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // Capture the request, then step the addresses and the multiply-accumulate
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg   <= req.row_index;
            col_reg   <= req.col_index;
            oob_reg   <= oob;
            inner_reg <= inner;
            a_ptr_reg <= a_start;
            b_ptr_reg <= b_start;
            a_far_reg <= (mode_eff == MODE_ATB);
            b_far_reg <= (mode_eff != MODE_ABT);
            acc_reg   <= '0;
        end
        else
        begin
            if (issue)
            begin
                a_ptr_reg <= a_ptr_reg + (a_far_reg ? AW'(MAX_DIM) : AW'(1));
                b_ptr_reg <= b_ptr_reg + (b_far_reg ? AW'(MAX_DIM) : AW'(1));
            end
            if (pv_reg)
                acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        prod_reg <= $signed(a_rdata) * $signed(b_rdata);
        sum_reg  <= acc_reg + (ACC_W'(1) <<< (FRAC - 1));
    end

    // Shift back to the element format and saturate
    always_comb
    begin
        shifted = sum_reg >>> FRAC;
        fits    = (&shifted[ACC_W-1:EW-1]) || !(|shifted[ACC_W-1:EW-1]);
        if (oob_reg)
        begin
            fin_value  = '0;
            fin_status = STATUS_RANGE;
        end
        else if (fits)
        begin
            fin_value  = shifted[EW-1:0];
            fin_status = STATUS_OK;
        end
        else
        begin
            fin_value  = sum_reg[ACC_W-1] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
            fin_status = STATUS_SAT;
        end
    end

    // Output register: hold the beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (load)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_row_reg    <= row_reg;
            res_col_reg    <= col_reg;
            res_value_reg  <= VAL_W'(fin_value);
            res_status_reg <= fin_status;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.out_row       = res_row_reg;
    assign res.out_col       = res_col_reg;
    assign res.product_value = res_value_reg;
    assign res.status        = res_status_reg;

    // Checks
    a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (cnt_reg <= inner_reg))
        else $error("element counter ran past the inner length");

    a_load_from_fin : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result beat raised outside the finish state");

    a_range_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_status_reg == STATUS_RANGE)) |-> (res_value_reg == '0))
        else $error("out-of-range result carries a non-zero value");

    a_drained : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (!dv_reg && !pv_reg))
        else $error("rounding started before the accumulator drained");

endmodule

`default_nettype wire
